FILE: sv/bpc_pkg.sv
// Shared widths, register indexes and types for the barometer compensation unit.
package bpc_pkg;

    localparam int RAW_W   = 20;
    localparam int TEMP_W  = 16;
    localparam int PRESS_W = 17;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_TEMP_CAL   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_PRESS_LOW  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_PRESS_HIGH = 2'd2;
    localparam logic [IDX_W-1:0] CFG_PRESS_LAST = 2'd3;

    localparam logic [PRESS_W-1:0] PRESS_MAX = 17'd131071;

    // payload that rides alongside the divider
    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              zero;
    } t_div_side;

endpackage

FILE: sv/bpc_in_if.sv
// Request channel carrying one pair of raw converter readings.
interface bpc_in_if;
    import bpc_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_temperature;
    logic [RAW_W-1:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

FILE: sv/bpc_out_if.sv
// Result channel carrying compensated temperature and pressure.
interface bpc_out_if;
    import bpc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic [PRESS_W-1:0]       pressure_pascal;
    logic                     divisor_zero;

    modport source (output valid, output temperature_centi, output pressure_pascal,
                    output divisor_zero, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_pascal,
                    input divisor_zero, output ready);
endinterface

FILE: sv/bpc_mul.sv
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
module bpc_mul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);
    import bpc_pkg::*;

    logic [63:0] r_ll;
    logic [31:0] r_cross;
    logic [63:0] r_p;

    // form partial products; cross terms only matter in their low half
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll    <= {32'b0, i_a[31:0]} * {32'b0, i_b[31:0]};
            r_cross <= 32'(i_a[31:0] * i_b[63:32]) + 32'(i_a[63:32] * i_b[31:0]);
        end
    end

    // combine partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_ll + {r_cross, 32'b0};
        end
    end

    assign o_p = r_p;
endmodule

FILE: sv/bpc_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
module bpc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [63:0]         i_num,
    input  logic [63:0]         i_den,
    input  bpc_pkg::t_div_side  i_side,
    output logic                o_valid,
    output logic [63:0]         o_quo,
    output bpc_pkg::t_div_side  o_side
);
    import bpc_pkg::*;

    localparam int STEPS = 64;

    logic [63:0] r_rem  [0:STEPS];
    logic [63:0] r_nq   [0:STEPS];
    logic [63:0] r_den  [0:STEPS];
    logic        r_neg  [0:STEPS];
    t_div_side   r_side [0:STEPS];
    logic        r_v    [0:STEPS];
    logic [63:0] r_quo;
    t_div_side   r_oside;
    logic        r_ov;

    // take magnitudes at entry, then restoring steps: shift one numerator
    // bit in, subtract when it fits
    always_ff @(posedge i_clk) begin
        logic [64:0] trial;
        logic        fits;
        if (i_en) begin
            r_rem[0]  <= 64'd0;
            r_nq[0]   <= i_num[63] ? 64'd0 - i_num : i_num;
            r_den[0]  <= i_den[63] ? 64'd0 - i_den : i_den;
            r_neg[0]  <= i_num[63] ^ i_den[63];
            r_side[0] <= i_side;
            for (int k = 0; k < STEPS; k++) begin
                trial = {r_rem[k], r_nq[k][63]};
                fits  = trial >= {1'b0, r_den[k]};
                r_rem[k+1]  <= fits ? 64'(trial - {1'b0, r_den[k]}) : trial[63:0];
                r_nq[k+1]   <= {r_nq[k][62:0], fits};
                r_den[k+1]  <= r_den[k];
                r_neg[k+1]  <= r_neg[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    // restore sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo   <= r_neg[STEPS] ? 64'd0 - r_nq[STEPS] : r_nq[STEPS];
            r_oside <= r_side[STEPS];
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < STEPS; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_ov <= r_v[STEPS];
        end
    end

    assign o_valid = r_ov;
    assign o_quo   = r_quo;
    assign o_side  = r_oside;
endmodule

FILE: sv/baro_temp_pressure_compensation_unit.sv
// Top level of the barometer temperature and pressure compensation pipeline.
//
// Usage:
//   i_in carries one request per item: a raw 20-bit temperature and a raw
//   20-bit pressure reading. o_out returns one result per request in order:
//   temperature in hundredths of a degree (saturated to 16 bits signed),
//   pressure in pascals (saturated to 0..131071) and a flag that is set,
//   with pressure 0, when the pressure divisor came out zero.
//   Calibration words are written through i_cfg_we / i_cfg_idx / i_cfg_data
//   while no request is in flight; indexes 0..3 select the four registers.
// Timing:
//   A request is taken in every cycle unless the pipeline holds behind a
//   blocked result. From acceptance to o_out.valid an item passes the
//   one-bit-per-stage divider, seven two-stage multiplier steps and the
//   glue stages around them.
// Reset and stalls:
//   Reset empties the pipeline and clears all calibration registers to 0.
//   A stalled result is held in the output register; the pipeline keeps
//   moving and taking requests until a finished item reaches its last stage,
//   then the whole pipeline holds until the result is taken.
module baro_temp_pressure_compensation_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bpc_in_if.sink                     i_in,
    bpc_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [bpc_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [bpc_pkg::CFG_W-1:0]  i_cfg_data
);
    import bpc_pkg::*;

    localparam int NPRE  = 13;
    localparam int NPOST = 5;

    // calibration registers
    logic [47:0] r_temp_cal;
    logic [63:0] r_press_low;
    logic [63:0] r_press_high;
    logic [15:0] r_press_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal   <= 48'd0;
            r_press_low  <= 64'd0;
            r_press_high <= 64'd0;
            r_press_last <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEMP_CAL:   r_temp_cal   <= i_cfg_data[47:0];
                CFG_PRESS_LOW:  r_press_low  <= i_cfg_data;
                CFG_PRESS_HIGH: r_press_high <= i_cfg_data;
                CFG_PRESS_LAST: r_press_last <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // coefficients, sign-extended except T1 and P1, which are zero-extended
    logic [31:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = {16'b0, r_temp_cal[15:0]};
    assign t2 = {{16{r_temp_cal[31]}}, r_temp_cal[31:16]};
    assign t3 = {{16{r_temp_cal[47]}}, r_temp_cal[47:32]};
    assign p1 = {48'b0, r_press_low[15:0]};
    assign p2 = {{48{r_press_low[31]}}, r_press_low[31:16]};
    assign p3 = {{48{r_press_low[47]}}, r_press_low[47:32]};
    assign p4 = {{48{r_press_low[63]}}, r_press_low[63:48]};
    assign p5 = {{48{r_press_high[15]}}, r_press_high[15:0]};
    assign p6 = {{48{r_press_high[31]}}, r_press_high[31:16]};
    assign p7 = {{48{r_press_high[47]}}, r_press_high[47:32]};
    assign p8 = {{48{r_press_high[63]}}, r_press_high[63:48]};
    assign p9 = {{48{r_press_last[15]}}, r_press_last};

    // pipeline enable: hold only when a finished item cannot leave
    logic en;
    logic r_o_valid;
    logic r_vpre  [0:NPRE-1];
    logic r_vpost [0:NPOST-1];

    assign en         = !r_o_valid || o_out.ready || !r_vpost[NPOST-1];
    assign i_in.ready = en;

    // input stage
    logic [RAW_W-1:0] r0_adct, r0_adcp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_adct <= i_in.raw_temperature;
            r0_adcp <= i_in.raw_pressure;
        end
    end

    // temperature products: (adc/8 - 2*T1)*T2 and (adc/16 - T1)^2
    logic [31:0] tx, ty;
    logic [63:0] m1a, m1b;
    assign tx = 32'(r0_adct >> 3) - {t1[30:0], 1'b0};
    assign ty = 32'(r0_adct >> 4) - t1;

    bpc_mul u_m1a (.i_clk(i_clk), .i_en(en), .i_a({32'b0, tx}), .i_b({32'b0, t2}), .o_p(m1a));
    bpc_mul u_m1b (.i_clk(i_clk), .i_en(en), .i_a({32'b0, ty}), .i_b({32'b0, ty}), .o_p(m1b));

    logic [RAW_W-1:0] r1_adcp, r2_adcp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_adcp <= r0_adcp;
            r2_adcp <= r1_adcp;
        end
    end

    // scale and multiply by T3
    logic [31:0] a32, b0;
    logic [63:0] m2;
    assign a32 = 32'($signed(m1a[31:0]) >>> 11);
    assign b0  = 32'($signed(m1b[31:0]) >>> 12);

    bpc_mul u_m2 (.i_clk(i_clk), .i_en(en), .i_a({32'b0, b0}), .i_b({32'b0, t3}), .o_p(m2));

    logic [31:0]      r3_a32, r4_a32;
    logic [RAW_W-1:0] r3_adcp, r4_adcp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_a32  <= a32;
            r3_adcp <= r2_adcp;
            r4_a32  <= r3_a32;
            r4_adcp <= r3_adcp;
        end
    end

    // fine temperature
    logic [31:0]      r5_fine;
    logic [RAW_W-1:0] r5_adcp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_fine <= r4_a32 + 32'($signed(m2[31:0]) >>> 14);
            r5_adcp <= r4_adcp;
        end
    end

    // temperature result and pressure offset
    logic [31:0]        f5;
    logic signed [31:0] tc;
    logic [TEMP_W-1:0]  t16;
    logic [63:0]        a64;
    logic [63:0]        m3a, m3b, m3c;

    assign f5  = {r5_fine[29:0], 2'b0} + r5_fine + 32'd128;
    assign tc  = $signed(f5) >>> 8;
    assign a64 = {{32{r5_fine[31]}}, r5_fine} - 64'd128000;

    always_comb begin
        if (tc > 32'sd32767) begin
            t16 = 16'h7fff;
        end else if (tc < -32'sd32768) begin
            t16 = 16'h8000;
        end else begin
            t16 = tc[15:0];
        end
    end

    bpc_mul u_m3a (.i_clk(i_clk), .i_en(en), .i_a(a64), .i_b(a64), .o_p(m3a));
    bpc_mul u_m3b (.i_clk(i_clk), .i_en(en), .i_a(a64), .i_b(p5),  .o_p(m3b));
    bpc_mul u_m3c (.i_clk(i_clk), .i_en(en), .i_a(a64), .i_b(p2),  .o_p(m3c));

    logic [TEMP_W-1:0] r6_t16, r7_t16;
    logic [RAW_W-1:0]  r6_adcp, r7_adcp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_t16  <= t16;
            r6_adcp <= r5_adcp;
            r7_t16  <= r6_t16;
            r7_adcp <= r6_adcp;
        end
    end

    // square terms times P6 and P3
    logic [63:0] m4a, m4b;
    bpc_mul u_m4a (.i_clk(i_clk), .i_en(en), .i_a(m3a), .i_b(p6), .o_p(m4a));
    bpc_mul u_m4b (.i_clk(i_clk), .i_en(en), .i_a(m3a), .i_b(p3), .o_p(m4b));

    logic [63:0]       r8_ap5, r8_ap2, r9_ap5, r9_ap2;
    logic [TEMP_W-1:0] r8_t16, r9_t16;
    logic [RAW_W-1:0]  r8_adcp, r9_adcp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_ap5  <= m3b;
            r8_ap2  <= m3c;
            r8_t16  <= r7_t16;
            r8_adcp <= r7_adcp;
            r9_ap5  <= r8_ap5;
            r9_ap2  <= r8_ap2;
            r9_t16  <= r8_t16;
            r9_adcp <= r8_adcp;
        end
    end

    // sum the offset and sensitivity terms
    logic [63:0]       r10_b, r10_s;
    logic [TEMP_W-1:0] r10_t16;
    logic [RAW_W-1:0]  r10_adcp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_b    <= m4a + {r9_ap5[46:0], 17'b0} + {p4[28:0], 35'b0};
            r10_s    <= 64'h0000_8000_0000_0000 + 64'($signed(m4b) >>> 8)
                        + {r9_ap2[51:0], 12'b0};
            r10_t16  <= r9_t16;
            r10_adcp <= r9_adcp;
        end
    end

    // divisor and dividend products
    logic [63:0] praw, nm, m5a, m5b;
    assign praw = 64'd1048576 - {44'b0, r10_adcp};
    assign nm   = {praw[32:0], 31'b0} - r10_b;

    bpc_mul u_m5a (.i_clk(i_clk), .i_en(en), .i_a(r10_s), .i_b(p1),       .o_p(m5a));
    bpc_mul u_m5b (.i_clk(i_clk), .i_en(en), .i_a(nm),    .i_b(64'd3125), .o_p(m5b));

    logic [TEMP_W-1:0] r11_t16, r12_t16;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_t16 <= r10_t16;
            r12_t16 <= r11_t16;
        end
    end

    // advance pre-divider valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NPRE; k++) begin
                r_vpre[k] <= 1'b0;
            end
        end else if (en) begin
            r_vpre[0] <= i_in.valid;
            for (int k = 1; k < NPRE; k++) begin
                r_vpre[k] <= r_vpre[k-1];
            end
        end
    end

    // divide
    logic [63:0] den, quo;
    t_div_side   dside, qside;
    logic        qvalid;
    assign den         = 64'($signed(m5a) >>> 33);
    assign dside.temp  = r12_t16;
    assign dside.zero  = (den == 64'd0);

    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vpre[NPRE-1]),
        .i_num   (m5b),
        .i_den   (den),
        .i_side  (dside),
        .o_valid (qvalid),
        .o_quo   (quo),
        .o_side  (qside)
    );

    // P8 term and squared quotient
    logic [63:0] ph, m6a, m6b;
    assign ph = 64'($signed(quo) >>> 13);

    bpc_mul u_m6a (.i_clk(i_clk), .i_en(en), .i_a(p8), .i_b(quo), .o_p(m6a));
    bpc_mul u_m6b (.i_clk(i_clk), .i_en(en), .i_a(ph), .i_b(ph),  .o_p(m6b));

    logic [63:0] r1_q, r2_q;
    t_div_side   r1_sd, r2_sd;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_q  <= quo;
            r1_sd <= qside;
            r2_q  <= r1_q;
            r2_sd <= r1_sd;
        end
    end

    // P9 term
    logic [63:0] m7;
    bpc_mul u_m7 (.i_clk(i_clk), .i_en(en), .i_a(p9), .i_b(m6b), .o_p(m7));

    logic [63:0] r3_q, r4_q, r3_d, r4_d;
    t_div_side   r3_sd, r4_sd;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_q  <= r2_q;
            r3_d  <= 64'($signed(m6a) >>> 19);
            r3_sd <= r2_sd;
            r4_q  <= r3_q;
            r4_d  <= r3_d;
            r4_sd <= r3_sd;
        end
    end

    // final pressure sum
    logic [63:0] psum;
    logic [63:0] r_fin_p;
    t_div_side   r_fin_sd;
    assign psum = r4_q + 64'($signed(m7) >>> 25) + r4_d;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fin_p  <= 64'($signed(psum) >>> 8) + {p7[59:0], 4'b0};
            r_fin_sd <= r4_sd;
        end
    end

    // advance post-divider valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NPOST; k++) begin
                r_vpost[k] <= 1'b0;
            end
        end else if (en) begin
            r_vpost[0] <= qvalid;
            for (int k = 1; k < NPOST; k++) begin
                r_vpost[k] <= r_vpost[k-1];
            end
        end
    end

    // clamp pressure
    logic [63:0]        ps;
    logic [PRESS_W-1:0] press;
    assign ps = 64'($signed(r_fin_p) >>> 8);

    always_comb begin
        if (r_fin_sd.zero || ps[63]) begin
            press = '0;
        end else if (ps > {47'b0, PRESS_MAX}) begin
            press = PRESS_MAX;
        end else begin
            press = ps[PRESS_W-1:0];
        end
    end

    // output register
    logic [TEMP_W-1:0]  r_o_temp;
    logic [PRESS_W-1:0] r_o_press;
    logic               r_o_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            if (en && r_vpost[NPOST-1]) begin
                r_o_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_vpost[NPOST-1]) begin
            r_o_temp  <= r_fin_sd.temp;
            r_o_press <= press;
            r_o_zero  <= r_fin_sd.zero;
        end
    end

    assign o_out.valid             = r_o_valid;
    assign o_out.temperature_centi = r_o_temp;
    assign o_out.pressure_pascal   = r_o_press;
    assign o_out.divisor_zero      = r_o_zero;

`ifndef NO_ASSERTIONS
    // a held request means a finished item is blocked behind a full output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_vpost[NPOST-1] && r_o_valid))
        else $error("input stalled without a blocked result");

    // a zero divisor always yields zero pressure
    a_zero_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.divisor_zero) |-> (o_out.pressure_pascal == '0))
        else $error("zero divisor with nonzero pressure");

    // an item leaving the last stage lands in the output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vpost[NPOST-1]) |=> r_o_valid)
        else $error("finished item lost at output");
`endif

endmodule
